[rtl/refcounted_lru_object_cache_top_assert.svh]
// Assertion macros for the object cache block.
// Needs nothing; included by the top level after its logic.
`ifndef REFCOUNTED_LRU_OBJECT_CACHE_TOP_ASSERT_SVH
`define REFCOUNTED_LRU_OBJECT_CACHE_TOP_ASSERT_SVH
// same-cycle implication
`define LRC_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define LRC_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`endif

[rtl/lrc_pkg.sv]
// Shared types and constants for the object cache block.
// No dependencies.
package lrc_pkg;

  localparam int TABLE_DEPTH_DEF     = 64;
  localparam int USER_COUNT_BITS_DEF = 16;
  localparam int KEY_BITS            = 64;
  localparam int RESULT_LIMIT        = 64;
  localparam logic [6:0] LIMIT_RESET = 7'd64;

  localparam logic [1:0] REQ_USE     = 2'd0;
  localparam logic [1:0] REQ_RELEASE = 2'd1;
  localparam logic [1:0] REQ_CLEAR   = 2'd2;
  localparam logic [1:0] REQ_RSVD    = 2'd3;  // no result

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_UNKNOWN   = 2'd2;
  localparam logic [1:0] STAT_UNDERFLOW = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] key_hash;
    logic        object_valid;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  slot;
    logic [63:0] entry_key;
    logic        hit;
    logic        replaced;
    logic        evicted;
    logic [6:0]  removed_count;
    logic [15:0] user_count;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE,
    ST_INSTALL
  } state_t;

endpackage

[rtl/lrc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/refcounted_lru_object_cache_top.sv]
// Top level of the reference-counted object cache with LRU eviction.
// Depends on lrc_pkg, lrc_ram and refcounted_lru_object_cache_top_assert.svh.
//
// Usage:
//  - Request word on in_data, taken at a clock edge with start high and busy low.
//    busy stays high while the request works; its closing result word is on
//    out_data in the first cycle with busy low, where a new request may be taken.
//  - Result words appear on out_data for exactly one cycle with out_valid high;
//    the receiver must take them, there is no back pressure. last marks the
//    final word of a request.
//  - cfg_data writes unused_limit when cfg_valid and cfg_ready are high; write
//    only while busy is low.
// Scanning: every request scans the table once through the entry RAM, one entry
//  a cycle, with busy high throughout. A miss on a full table adds the INSTALL
//  state for the install word. A release that evicts k entries rescans once per
//  eviction, so it makes k + 1 scans in all. The single compare unit in the scan
//  loop (key match and oldest-serial search) sets this pace.
// Reset (rst_n low, synchronous): all entries invalid, serial and unused count
//  zero, unused_limit back to 64. No clearing pass is needed.
module refcounted_lru_object_cache_top #(
  parameter int TABLE_DEPTH     = lrc_pkg::TABLE_DEPTH_DEF,
  parameter int USER_COUNT_BITS = lrc_pkg::USER_COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  lrc_pkg::in_item_t in_data,
  output logic              out_valid,
  output lrc_pkg::out_item_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [6:0]        cfg_data
);

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int CNTW = $clog2(TABLE_DEPTH + 1);
  localparam int CW   = (CNTW > 7) ? CNTW : 7;
  localparam int UCB  = USER_COUNT_BITS;
  localparam int KB   = lrc_pkg::KEY_BITS;
  localparam int EW   = KB + UCB + KB;   // entry word: {key, users, last_use}

  lrc_pkg::state_t state_r, state_nxt;

  logic [1:0]             req_r, req_nxt;
  logic [KB-1:0]          key_r, key_nxt;
  logic                   objv_r, objv_nxt;
  logic [CNTW-1:0]        cnt_r, cnt_nxt;
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [63:0]            serial_r, serial_nxt;
  logic [CNTW-1:0]        unused_r, unused_nxt;
  logic [6:0]             limit_r, limit_nxt;
  logic                   evicting_r, evicting_nxt;
  logic [6:0]             nres_r, nres_nxt;
  logic [CNTW-1:0]        removed_r, removed_nxt;

  // scan trackers
  logic                   match_f_r, match_f_nxt;
  logic [AW-1:0]          match_idx_r, match_idx_nxt;
  logic [UCB-1:0]         match_users_r, match_users_nxt;
  logic                   free_f_r, free_f_nxt;
  logic [AW-1:0]          free_idx_r, free_idx_nxt;
  logic                   old_f_r, old_f_nxt;
  logic [AW-1:0]          old_idx_r, old_idx_nxt;
  logic [63:0]            old_last_r, old_last_nxt;
  logic [KB-1:0]          old_key_r, old_key_nxt;

  logic                   out_valid_r, out_valid_nxt;
  lrc_pkg::out_item_t     out_data_r, out_data_nxt;

  // RAM port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_rdata;

  // decisions for the sequencer
  logic go_install, go_rescan;

  logic           accept;
  logic [AW-1:0]  idx;
  logic [KB-1:0]  rd_key;
  logic [UCB-1:0] rd_users;
  logic [63:0]    rd_last;
  logic           scan_last;

  assign accept    = start && (state_r == lrc_pkg::ST_IDLE);
  assign busy      = (state_r != lrc_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign idx       = AW'(cnt_r - CNTW'(1));
  assign rd_last   = ram_rdata[63:0];
  assign rd_users  = ram_rdata[64 +: UCB];
  assign rd_key    = ram_rdata[64 + UCB +: KB];
  assign scan_last = (cnt_r == CNTW'(TABLE_DEPTH));

  lrc_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lrc_pkg::ST_IDLE: begin
        if (accept) state_nxt = lrc_pkg::ST_SCAN;
      end
      lrc_pkg::ST_SCAN: begin
        if (scan_last) state_nxt = lrc_pkg::ST_DONE;
      end
      lrc_pkg::ST_DONE: begin
        if (go_install)     state_nxt = lrc_pkg::ST_INSTALL;
        else if (go_rescan) state_nxt = lrc_pkg::ST_SCAN;
        else                state_nxt = lrc_pkg::ST_IDLE;
      end
      lrc_pkg::ST_INSTALL: state_nxt = lrc_pkg::ST_IDLE;
      default: state_nxt = lrc_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    logic [UCB-1:0] new_users;
    logic [CNTW-1:0] u_new;
    logic more;
    lrc_pkg::out_item_t res;

    req_nxt         = req_r;
    key_nxt         = key_r;
    objv_nxt        = objv_r;
    cnt_nxt         = cnt_r;
    valid_nxt       = valid_r;
    serial_nxt      = serial_r;
    unused_nxt      = unused_r;
    limit_nxt       = limit_r;
    evicting_nxt    = evicting_r;
    nres_nxt        = nres_r;
    removed_nxt     = removed_r;
    match_f_nxt     = match_f_r;
    match_idx_nxt   = match_idx_r;
    match_users_nxt = match_users_r;
    free_f_nxt      = free_f_r;
    free_idx_nxt    = free_idx_r;
    old_f_nxt       = old_f_r;
    old_idx_nxt     = old_idx_r;
    old_last_nxt    = old_last_r;
    old_key_nxt     = old_key_r;
    out_valid_nxt   = 1'b0;
    out_data_nxt    = out_data_r;
    ram_we          = 1'b0;
    ram_waddr       = '0;
    ram_wdata       = '0;
    go_install      = 1'b0;
    go_rescan       = 1'b0;
    new_users       = '0;
    u_new           = unused_r;
    more            = 1'b0;
    res             = '0;

    if (cfg_valid) limit_nxt = cfg_data;

    case (state_r)
      lrc_pkg::ST_IDLE: begin
        if (accept) begin
          req_nxt      = in_data.req_type;
          key_nxt      = in_data.key_hash;
          objv_nxt     = in_data.object_valid;
          evicting_nxt = 1'b0;
          nres_nxt     = '0;
          cnt_nxt      = '0;
          removed_nxt  = '0;
          match_f_nxt  = 1'b0;
          free_f_nxt   = 1'b0;
          old_f_nxt    = 1'b0;
        end
      end

      lrc_pkg::ST_SCAN: begin
        cnt_nxt = cnt_r + CNTW'(1);
        if (cnt_r != '0) begin
          if (!valid_r[idx]) begin
            if (!free_f_r) begin
              free_f_nxt   = 1'b1;
              free_idx_nxt = idx;
            end
          end else begin
            if (!match_f_r && rd_key == key_r) begin
              match_f_nxt     = 1'b1;
              match_idx_nxt   = idx;
              match_users_nxt = rd_users;
            end
            if (rd_users == '0) begin
              if (!old_f_r || rd_last < old_last_r) begin
                old_f_nxt    = 1'b1;
                old_idx_nxt  = idx;
                old_last_nxt = rd_last;
                old_key_nxt  = rd_key;
              end
              if (req_r == lrc_pkg::REQ_CLEAR) begin
                valid_nxt[idx] = 1'b0;
                removed_nxt    = removed_r + CNTW'(1);
              end
            end
          end
        end
      end

      lrc_pkg::ST_DONE: begin
        res.entry_key = key_r;
        res.last      = 1'b1;
        case (req_r)
          lrc_pkg::REQ_USE: begin
            out_valid_nxt = 1'b1;
            if (match_f_r && !(!objv_r && match_users_r == '0)) begin
              new_users = (match_users_r == {UCB{1'b1}}) ? match_users_r
                                                          : match_users_r + UCB'(1);
              if (match_users_r == '0 && unused_r != '0) unused_nxt = unused_r - CNTW'(1);
              serial_nxt = serial_r + 64'd1;
              ram_we     = 1'b1;
              ram_waddr  = match_idx_r;
              ram_wdata  = {key_r, new_users, serial_r + 64'd1};
              res.slot       = 6'(match_idx_r);
              res.hit        = 1'b1;
              res.user_count = 16'(new_users);
            end else if (match_f_r || free_f_r) begin
              if (match_f_r && unused_r != '0) unused_nxt = unused_r - CNTW'(1);
              ram_waddr  = match_f_r ? match_idx_r : free_idx_r;
              serial_nxt = serial_r + 64'd1;
              ram_we     = 1'b1;
              ram_wdata  = {key_r, UCB'(1), serial_r + 64'd1};
              valid_nxt[ram_waddr] = 1'b1;
              res.slot       = 6'(ram_waddr);
              res.replaced   = match_f_r;
              res.user_count = 16'(1);
            end else if (old_f_r) begin
              // full table: evict the oldest unused entry, install next cycle
              valid_nxt[old_idx_r] = 1'b0;
              if (unused_r != '0) unused_nxt = unused_r - CNTW'(1);
              res.slot      = 6'(old_idx_r);
              res.entry_key = old_key_r;
              res.evicted   = 1'b1;
              res.last      = 1'b0;
              go_install    = 1'b1;
            end else begin
              res.status = lrc_pkg::STAT_FULL;
            end
          end

          lrc_pkg::REQ_RELEASE: begin
            if (evicting_r) begin
              if (old_f_r) begin
                out_valid_nxt = 1'b1;
                valid_nxt[old_idx_r] = 1'b0;
                u_new      = (unused_r != '0) ? unused_r - CNTW'(1) : unused_r;
                unused_nxt = u_new;
                nres_nxt   = nres_r + 7'd1;
                more = (CW'(u_new) > CW'(limit_r)) &&
                       (nres_r + 7'd1 < 7'(lrc_pkg::RESULT_LIMIT));
                res.slot      = 6'(old_idx_r);
                res.entry_key = old_key_r;
                res.evicted   = 1'b1;
                res.last      = !more;
                go_rescan     = more;
              end
            end else if (!match_f_r) begin
              out_valid_nxt = 1'b1;
              res.status    = lrc_pkg::STAT_UNKNOWN;
            end else if (match_users_r == '0) begin
              out_valid_nxt = 1'b1;
              res.slot      = 6'(match_idx_r);
              res.status    = lrc_pkg::STAT_UNDERFLOW;
            end else begin
              out_valid_nxt = 1'b1;
              new_users  = match_users_r - UCB'(1);
              u_new      = (new_users == '0) ? unused_r + CNTW'(1) : unused_r;
              unused_nxt = u_new;
              serial_nxt = serial_r + 64'd1;
              ram_we     = 1'b1;
              ram_waddr  = match_idx_r;
              ram_wdata  = {key_r, new_users, serial_r + 64'd1};
              nres_nxt   = 7'd1;
              more = (CW'(u_new) > CW'(limit_r)) &&
                     (7'd1 < 7'(lrc_pkg::RESULT_LIMIT));
              res.slot       = 6'(match_idx_r);
              res.user_count = 16'(new_users);
              res.last       = !more;
              go_rescan      = more;
            end
            if (go_rescan) begin
              evicting_nxt = 1'b1;
              cnt_nxt      = '0;
              match_f_nxt  = 1'b0;
              free_f_nxt   = 1'b0;
              old_f_nxt    = 1'b0;
            end
          end

          lrc_pkg::REQ_CLEAR: begin
            out_valid_nxt     = 1'b1;
            unused_nxt        = '0;
            res.entry_key     = '0;
            res.removed_count = 7'(removed_r);
          end

          default: ;  // unknown request: no result
        endcase
        out_data_nxt = res;
      end

      lrc_pkg::ST_INSTALL: begin
        serial_nxt = serial_r + 64'd1;
        ram_we     = 1'b1;
        ram_waddr  = old_idx_r;
        ram_wdata  = {key_r, UCB'(1), serial_r + 64'd1};
        valid_nxt[old_idx_r] = 1'b1;
        out_valid_nxt  = 1'b1;
        res.slot       = 6'(old_idx_r);
        res.entry_key  = key_r;
        res.user_count = 16'(1);
        res.last       = 1'b1;
        out_data_nxt   = res;
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lrc_pkg::ST_IDLE;
      valid_r     <= '0;
      serial_r    <= '0;
      unused_r    <= '0;
      limit_r     <= lrc_pkg::LIMIT_RESET;
      out_valid_r <= 1'b0;
      evicting_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      serial_r    <= serial_nxt;
      unused_r    <= unused_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
      evicting_r  <= evicting_nxt;
    end
    req_r         <= req_nxt;
    key_r         <= key_nxt;
    objv_r        <= objv_nxt;
    cnt_r         <= cnt_nxt;
    nres_r        <= nres_nxt;
    removed_r     <= removed_nxt;
    match_f_r     <= match_f_nxt;
    match_idx_r   <= match_idx_nxt;
    match_users_r <= match_users_nxt;
    free_f_r      <= free_f_nxt;
    free_idx_r    <= free_idx_nxt;
    old_f_r       <= old_f_nxt;
    old_idx_r     <= old_idx_nxt;
    old_last_r    <= old_last_nxt;
    old_key_r     <= old_key_nxt;
    out_data_r    <= out_data_nxt;
  end

  `include "refcounted_lru_object_cache_top_assert.svh"

  // a result word only follows a cycle spent working on a request
  `LRC_ASSERT_NOW(a_out_after_busy, clk, rst_n, out_valid, $past(busy), "result while idle")
  // accepted request always starts a table scan
  `LRC_ASSERT_NXT(a_accept_scan, clk, rst_n, accept, state_r == lrc_pkg::ST_SCAN, "no scan")
  // install after eviction is always the closing word
  `LRC_ASSERT_NXT(a_install_last, clk, rst_n, state_r == lrc_pkg::ST_INSTALL,
                  out_valid && out_data.last, "install word missing")
  // unused count never exceeds the table
  `LRC_ASSERT_NOW(a_unused_bound, clk, rst_n, 1'b1,
                  unused_r <= CNTW'(TABLE_DEPTH), "unused count overflow")

endmodule
